/* hw/rtl/tdpt_pkg.sv */
// Shared constants for the trial-division prime test unit.
package tdpt_pkg;

	// Width of the candidate field on the input channel.
	localparam int CAND_BITS = 32;

	// Default width of the arithmetic datapath.
	localparam int VALUE_BITS_DEF = 32;

	// Smallest divisor tried, and the smallest prime.
	localparam int FIRST_DIVISOR = 2;

endpackage

/* hw/rtl/tdpt_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module tdpt_divider import tdpt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [VALUE_BITS-1:0]                  dividend,
	input  logic [(VALUE_BITS+1)/2:0]              divisor,
	output logic                                   done,
	output logic [VALUE_BITS-1:0]                  quotient,
	output logic [(VALUE_BITS+1)/2:0]              remainder
);

	localparam int DW = (VALUE_BITS + 1) / 2 + 1;
	localparam int CW = $clog2(VALUE_BITS);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dsr_q;

	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            fits;
	logic [DW-1:0]   rem_nxt;

	// Shift the next dividend bit into the partial remainder; subtract when it fits.
	always_comb begin
		trial   = {rem_q, dvd_q[VALUE_BITS-1]};
		diff    = trial - {1'b0, dsr_q};
		fits    = trial >= {1'b0, dsr_q};
		rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(VALUE_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hw/rtl/trial_division_prime_test_unit.sv */
// Top level of the trial-division prime test unit.
//
//   channel   direction  handshake                  payload
//   cand      in         cand_valid / cand_stall    candidate[31:0]
//   result    out        result_valid / result_stall is_prime
//
// Search: each divisor is one pass of the bit-serial divider, which yields
//   quotient and remainder together; divisors are tried one at a time, and
//   candidates 0 and 1 skip the divider. A 32-bit prime near 2^32 tries about
//   65535 divisors.
// Reset: arst_n clears the control state; the block is then idle and ready.
// Stalls: the result sits in an output register, so a new item is taken while it
//   waits; a finished search holds until that register is free.
module trial_division_prime_test_unit import tdpt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cand_valid,
	output logic                 cand_stall,
	input  logic [CAND_BITS-1:0] candidate,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 is_prime
);

	localparam int DW = (VALUE_BITS + 1) / 2 + 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic [DW-1:0]         dvs_q;
	logic                  res_q;
	logic                  result_valid_q;
	logic                  is_prime_q;

	logic [VALUE_BITS-1:0] cand_in;
	logic                  accept;
	logic                  out_free;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [DW-1:0]         div_divisor;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DW-1:0]         div_rem;
	logic                  past_bound;
	logic                  exact;

	// Keep only the low VALUE_BITS of the candidate.
	assign cand_in    = VALUE_BITS'(candidate);
	assign cand_stall = (state_q != ST_IDLE);
	assign accept     = cand_valid && !cand_stall;
	assign out_free   = !result_valid_q || !result_stall;

	// The search ends once the divisor exceeds candidate / divisor.
	assign past_bound = VALUE_BITS'(dvs_q) > div_quo;
	assign exact      = (div_rem == '0);

	// Launch a division on a fresh candidate of at least FIRST_DIVISOR, or on the next divisor when the
	// last one left a remainder and the bound still holds.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = cand_q;
		div_divisor  = DW'(dvs_q + 1'b1);
		case (state_q)
			ST_IDLE: begin
				div_dividend = cand_in;
				div_divisor  = DW'(FIRST_DIVISOR);
				div_start    = accept && (cand_in >= VALUE_BITS'(FIRST_DIVISOR));
			end
			ST_RUN: begin
				div_start = div_done && !past_bound && !exact;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Zero and one skip the search entirely.
						state_q <= (cand_in >= VALUE_BITS'(FIRST_DIVISOR)) ?
							ST_RUN : ST_FINISH;
					end
				end
				ST_RUN: begin
					if (div_done && (past_bound || exact)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: candidate, current divisor, verdict, output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= cand_in;
			res_q  <= 1'b0;
		end
		if (div_start) begin
			dvs_q <= div_divisor;
		end
		if (state_q == ST_RUN && div_done) begin
			// Past the bound with no exact divisor means prime.
			res_q <= past_bound;
		end
		if (state_q == ST_FINISH && out_free) begin
			is_prime_q <= res_q;
		end
	end

	tdpt_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign result_valid = result_valid_q;
	assign is_prime     = is_prime_q;

endmodule

/* hw/rtl/tdpt_checker.sv */
// Port-level checks on the trial-division prime test unit, with its bind.
module tdpt_checker import tdpt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cand_valid,
	input logic                 cand_stall,
	input logic [CAND_BITS-1:0] candidate,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic                 is_prime
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(is_prime))
		else $error("result dropped or changed under stall");

	// Once an item is taken the block is busy until its search is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && !cand_stall |=> cand_stall)
		else $error("second item taken during a search");

	// Delivering a verdict frees the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !cand_stall)
		else $error("input still stalled after verdict");

	// Zero and one never come out prime.
	assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && !cand_stall && (candidate[CAND_BITS-1:1] == '0) &&
		!result_valid |=> ##1 !(result_valid && is_prime))
		else $error("zero or one reported prime");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cand_valid   (cand_valid),
	.cand_stall   (cand_stall),
	.candidate    (candidate),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.is_prime     (is_prime)
);
